/* rtl/pointer_position_tracker_assert.svh */
`ifndef POINTER_POSITION_TRACKER_ASSERT_SVH
`define POINTER_POSITION_TRACKER_ASSERT_SVH

// Check that a condition implies another in the same cycle
`define PPT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("pointer position tracker: check failed");

// Check that a condition implies another in the following cycle
`define PPT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("pointer position tracker: sequence check failed");

`endif

/* rtl/ppt_pkg.sv */
package ppt_pkg;

	// Default cursor coordinate width
	localparam int COORD_BITS_DEF = 12;
	// Devices that may report absolute positions
	localparam int DEVICE_COUNT = 2;

	// Stream and register port widths
	localparam int S_TDATA_W = 48;
	localparam int S_TUSER_W = 5;
	localparam int M_TDATA_W = 40;
	localparam int APB_ADDR_W = 5;
	localparam int APB_DATA_W = 32;

	// Event classes
	localparam logic [4:0] EVT_KEY = 5'd1;
	localparam logic [4:0] EVT_REL = 5'd2;
	localparam logic [4:0] EVT_ABS = 5'd3;

	// Axis and button codes
	localparam logic [9:0] AXIS_X = 10'd0;
	localparam logic [9:0] AXIS_Y = 10'd1;
	localparam logic [9:0] CODE_BTN_BASE = 10'h110;
	localparam logic [9:0] CODE_BTN_LEFT = 10'h110;
	localparam logic [9:0] CODE_BTN_RIGHT = 10'h111;

	// Register reset values
	localparam logic [12:0] RST_SCREEN_WIDTH = 13'd1024;
	localparam logic [12:0] RST_SCREEN_HEIGHT = 13'd768;
	localparam logic [31:0] RST_RAW_MIN = 32'd0;
	localparam logic [31:0] RST_RAW_MAX = 32'd32767;
	localparam logic [1:0] RST_ABS_MASK = 2'd0;

	// Register indexes (word address)
	typedef enum logic [2:0] {
		REG_SCREEN_WIDTH = 3'd0,
		REG_SCREEN_HEIGHT = 3'd1,
		REG_RAW_MIN_X = 3'd2,
		REG_RAW_MAX_X = 3'd3,
		REG_RAW_MIN_Y = 3'd4,
		REG_RAW_MAX_Y = 3'd5,
		REG_ABS_MASK = 3'd6
	} ppt_reg_t;

	// Configuration bundle from the register file
	typedef struct packed {
		logic [12:0] screen_width;
		logic [12:0] screen_height;
		logic [31:0] raw_min_x;
		logic [31:0] raw_max_x;
		logic [31:0] raw_min_y;
		logic [31:0] raw_max_y;
		logic [1:0] abs_device_mask;
	} ppt_cfg_t;

	// Status of the serial scaling unit
	typedef struct packed {
		logic busy;
		logic done;
	} ppt_arith_stat_t;

endpackage

/* rtl/ppt_regs.sv */
module ppt_regs (
	input  logic clk,
	input  logic arst_n,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [ppt_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [ppt_pkg::APB_DATA_W-1:0] pwdata,
	output logic [ppt_pkg::APB_DATA_W-1:0] prdata,
	output logic pready,
	output ppt_pkg::ppt_cfg_t cfg
);

	ppt_pkg::ppt_cfg_t cfg_q;
	ppt_pkg::ppt_reg_t reg_idx;
	logic wr_en;

	assign pready = 1'b1;
	assign reg_idx = ppt_pkg::ppt_reg_t'(paddr[4:2]);
	assign wr_en = psel && penable && pwrite && pready;
	assign cfg = cfg_q;

	// Write on the access phase; unused indexes drop the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.screen_width <= ppt_pkg::RST_SCREEN_WIDTH;
			cfg_q.screen_height <= ppt_pkg::RST_SCREEN_HEIGHT;
			cfg_q.raw_min_x <= ppt_pkg::RST_RAW_MIN;
			cfg_q.raw_max_x <= ppt_pkg::RST_RAW_MAX;
			cfg_q.raw_min_y <= ppt_pkg::RST_RAW_MIN;
			cfg_q.raw_max_y <= ppt_pkg::RST_RAW_MAX;
			cfg_q.abs_device_mask <= ppt_pkg::RST_ABS_MASK;
		end else if (wr_en) begin
			case (reg_idx)
				ppt_pkg::REG_SCREEN_WIDTH: cfg_q.screen_width <= pwdata[12:0];
				ppt_pkg::REG_SCREEN_HEIGHT: cfg_q.screen_height <= pwdata[12:0];
				ppt_pkg::REG_RAW_MIN_X: cfg_q.raw_min_x <= pwdata;
				ppt_pkg::REG_RAW_MAX_X: cfg_q.raw_max_x <= pwdata;
				ppt_pkg::REG_RAW_MIN_Y: cfg_q.raw_min_y <= pwdata;
				ppt_pkg::REG_RAW_MAX_Y: cfg_q.raw_max_y <= pwdata;
				ppt_pkg::REG_ABS_MASK: cfg_q.abs_device_mask <= pwdata[1:0];
				default: ;
			endcase
		end
	end

	// Read back the addressed register
	always_comb begin
		case (reg_idx)
			ppt_pkg::REG_SCREEN_WIDTH: prdata = {19'd0, cfg_q.screen_width};
			ppt_pkg::REG_SCREEN_HEIGHT: prdata = {19'd0, cfg_q.screen_height};
			ppt_pkg::REG_RAW_MIN_X: prdata = cfg_q.raw_min_x;
			ppt_pkg::REG_RAW_MAX_X: prdata = cfg_q.raw_max_x;
			ppt_pkg::REG_RAW_MIN_Y: prdata = cfg_q.raw_min_y;
			ppt_pkg::REG_RAW_MAX_Y: prdata = cfg_q.raw_max_y;
			ppt_pkg::REG_ABS_MASK: prdata = {30'd0, cfg_q.abs_device_mask};
			default: prdata = '0;
		endcase
	end

endmodule

/* rtl/ppt_scaler.sv */
`include "pointer_position_tracker_assert.svh"

// Bit-serial scaler: quo = floor(diff * lim / range), for diff < range.
// Shift-add multiply, then restoring divide in the same shift register.
module ppt_scaler #(
	parameter int COORD_BITS = ppt_pkg::COORD_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [31:0] diff,
	input  logic [31:0] range,
	input  logic [COORD_BITS-1:0] lim,
	output ppt_pkg::ppt_arith_stat_t stat,
	output logic [COORD_BITS-1:0] quo
);

	localparam int ProdW = 32 + COORD_BITS;
	localparam int CntW = $clog2(COORD_BITS);

	typedef enum logic [2:0] {
		SC_IDLE = 3'b001,
		SC_MUL = 3'b010,
		SC_DIV = 3'b100
	} sc_state_t;

	sc_state_t state_q;
	logic [CntW-1:0] cnt_q;
	logic done_q;
	logic [ProdW-1:0] prod_q;
	logic [31:0] mcand_q;
	logic [31:0] dvs_q;
	logic [COORD_BITS-1:0] lim_q;

	logic [32:0] mul_sum;
	logic [32:0] trial;
	logic [32:0] trial_sub;
	logic trial_ge;

	// One multiplier bit: add the multiplicand into the upper half
	assign mul_sum = {1'b0, prod_q[ProdW-1:COORD_BITS]} + (prod_q[0] ? {1'b0, mcand_q} : 33'd0);

	// One quotient bit: bring down the next numerator bit and try the divisor
	assign trial = {prod_q[ProdW-1:COORD_BITS], prod_q[COORD_BITS-1]};
	assign trial_ge = trial >= {1'b0, dvs_q};
	assign trial_sub = trial - {1'b0, dvs_q};

	assign stat.busy = (state_q != SC_IDLE);
	assign stat.done = done_q;
	assign quo = prod_q[COORD_BITS-1:0];

	// Sequence the two phases
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SC_IDLE;
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (state_q == SC_DIV) && (cnt_q == '0);
			case (state_q)
				SC_IDLE: begin
					if (start) begin
						state_q <= SC_MUL;
						cnt_q <= CntW'(COORD_BITS - 1);
					end
				end
				SC_MUL: begin
					if (cnt_q == '0) begin
						state_q <= SC_DIV;
						cnt_q <= CntW'(COORD_BITS - 1);
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				SC_DIV: begin
					if (cnt_q == '0) begin
						state_q <= SC_IDLE;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				default: state_q <= SC_IDLE;
			endcase
		end
	end

	// Operand and product shift register
	always_ff @(posedge clk) begin
		case (state_q)
			SC_IDLE: begin
				if (start) begin
					prod_q <= {32'd0, lim};
					mcand_q <= diff;
					dvs_q <= range;
					lim_q <= lim;
				end
			end
			SC_MUL: prod_q <= {mul_sum, prod_q[COORD_BITS-1:1]};
			SC_DIV: begin
				prod_q <= {(trial_ge ? trial_sub[31:0] : trial[31:0]),
					prod_q[COORD_BITS-2:0], trial_ge};
			end
			default: ;
		endcase
	end

	`PPT_ASSERT_NOW(a_quo_below_lim, clk, arst_n, done_q, (quo < lim_q) || (quo == '0))

endmodule

/* rtl/pointer_position_tracker.sv */
// Pointer position tracker.
// Input events arrive as beats on the s_axis channel (tuser: event type,
// tdata: code, value, device index). Each event yields exactly one result
// beat on m_axis (tdata: cursor x/y, redraw, button edges, key press/code).
// Configuration goes through the APB port; write it only while idle.
// Key, relative and ignored events pass through the PREP, EXEC and FIN
// states from accept to result valid. Absolute axis events that need
// scaling also wait in WAIT for the bit-serial multiply and divide in
// the scaler, one bit per cycle each. A new event is taken while the
// previous result waits in the output register.
// Reset clears the cursor to (0,0), releases both buttons and loads the
// register defaults (1024x768 screen, raw range 0..32767, no absolute
// device). When the receiver stalls, the result holds in the output
// register and the tracker stops before loading the next result.
`include "pointer_position_tracker_assert.svh"

module pointer_position_tracker #(
	parameter int COORD_BITS = ppt_pkg::COORD_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// [9:0] event_code, [41:10] event_value, [42] device_index, [47:43] zero
	input  logic [ppt_pkg::S_TDATA_W-1:0] s_axis_tdata,
	// [4:0] event_type
	input  logic [ppt_pkg::S_TUSER_W-1:0] s_axis_tuser,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// [11:0] cursor_x, [23:12] cursor_y, [24] redraw, [25] left_pressed,
	// [26] left_released, [27] right_pressed, [28] key_pressed,
	// [38:29] key_code, [39] zero
	output logic [ppt_pkg::M_TDATA_W-1:0] m_axis_tdata,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [ppt_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [ppt_pkg::APB_DATA_W-1:0] pwdata,
	output logic [ppt_pkg::APB_DATA_W-1:0] prdata,
	output logic pready
);

	localparam int Cap = 1 << COORD_BITS;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_PREP = 5'b00010,
		ST_EXEC = 5'b00100,
		ST_WAIT = 5'b01000,
		ST_FIN = 5'b10000
	} ppt_state_t;

	ppt_pkg::ppt_cfg_t cfg;
	ppt_pkg::ppt_arith_stat_t arith_stat;
	logic [COORD_BITS-1:0] quo;

	ppt_state_t state_q;
	logic [4:0] ev_type_q;
	logic [9:0] ev_code_q;
	logic [31:0] ev_value_q;
	logic ev_dev_q;
	logic [32:0] diff_q;
	logic [32:0] range_q;

	logic [COORD_BITS-1:0] cursor_x_q;
	logic [COORD_BITS-1:0] cursor_y_q;
	logic left_level_q;
	logic right_level_q;
	logic redraw_q;
	logic lp_q;
	logic lr_q;
	logic rp_q;
	logic kp_q;
	logic m_valid_q;
	logic [ppt_pkg::M_TDATA_W-1:0] m_data_q;

	logic [COORD_BITS-1:0] lim_x;
	logic [COORD_BITS-1:0] lim_y;
	logic [COORD_BITS-1:0] clamp_x;
	logic [COORD_BITS-1:0] clamp_y;
	logic tgt_x;
	logic tgt_y;
	logic [COORD_BITS-1:0] cur_tgt;
	logic [COORD_BITS-1:0] lim_tgt;
	logic [COORD_BITS-1:0] clamp_tgt;
	logic is_rel;
	logic is_abs;
	logic is_key;
	logic motion;
	logic btn_down;
	logic range_pos;
	logic diff_neg;
	logic diff_lt_range;
	logic need_div;
	logic [33:0] rel_sum;
	logic [COORD_BITS-1:0] rel_val;
	logic [COORD_BITS-1:0] abs_val;
	logic [COORD_BITS-1:0] axis_new;
	logic accept;
	logic out_free;

	ppt_regs u_regs (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.cfg(cfg)
	);

	ppt_scaler #(
		.COORD_BITS(COORD_BITS)
	) u_scaler (
		.clk(clk),
		.arst_n(arst_n),
		.start(state_q == ST_EXEC && need_div),
		.diff(diff_q[31:0]),
		.range(range_q[31:0]),
		.lim(lim_tgt),
		.stat(arith_stat),
		.quo(quo)
	);

	// Effective clamp limits: a zero screen acts as one, oversize saturates
	assign lim_x = (cfg.screen_width == '0) ? '0 :
		(int'(cfg.screen_width) > Cap) ? '1 : COORD_BITS'(cfg.screen_width - 13'd1);
	assign lim_y = (cfg.screen_height == '0) ? '0 :
		(int'(cfg.screen_height) > Cap) ? '1 : COORD_BITS'(cfg.screen_height - 13'd1);
	assign clamp_x = (cursor_x_q > lim_x) ? lim_x : cursor_x_q;
	assign clamp_y = (cursor_y_q > lim_y) ? lim_y : cursor_y_q;

	// Decode the held event
	assign tgt_x = (ev_code_q == ppt_pkg::AXIS_X);
	assign tgt_y = (ev_code_q == ppt_pkg::AXIS_Y);
	assign cur_tgt = tgt_y ? cursor_y_q : cursor_x_q;
	assign lim_tgt = tgt_y ? lim_y : lim_x;
	assign clamp_tgt = tgt_y ? clamp_y : clamp_x;
	assign is_rel = (ev_type_q == ppt_pkg::EVT_REL);
	assign is_abs = (ev_type_q == ppt_pkg::EVT_ABS) && (int'(ev_dev_q) < ppt_pkg::DEVICE_COUNT)
		&& cfg.abs_device_mask[ev_dev_q];
	assign is_key = (ev_type_q == ppt_pkg::EVT_KEY);
	assign motion = is_rel || is_abs;
	assign btn_down = (ev_value_q != '0);

	// Relative move: add the delta, then clamp to the screen
	assign rel_sum = {{2{ev_value_q[31]}}, ev_value_q} + 34'(cur_tgt);
	assign rel_val = rel_sum[33] ? '0 :
		(rel_sum > 34'(lim_tgt)) ? lim_tgt : rel_sum[COORD_BITS-1:0];

	// Absolute move: trivial cases here, the rest goes to the scaler
	assign range_pos = !range_q[32] && (range_q != '0);
	assign diff_neg = diff_q[32];
	assign diff_lt_range = diff_q < range_q;
	assign abs_val = !range_pos ? clamp_tgt : diff_neg ? '0 : lim_tgt;
	assign need_div = is_abs && (tgt_x || tgt_y) && range_pos && !diff_neg && diff_lt_range;
	assign axis_new = is_rel ? rel_val : abs_val;

	assign accept = s_axis_tvalid && s_axis_tready;
	assign out_free = !m_valid_q || m_axis_tready;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata = m_data_q;

	// Capture the event and the scaling operands
	always_ff @(posedge clk) begin
		if (accept) begin
			ev_type_q <= s_axis_tuser[4:0];
			ev_code_q <= s_axis_tdata[9:0];
			ev_value_q <= s_axis_tdata[41:10];
			ev_dev_q <= s_axis_tdata[42];
		end
		if (state_q == ST_PREP) begin
			if (tgt_y) begin
				diff_q <= {ev_value_q[31], ev_value_q} - {cfg.raw_min_y[31], cfg.raw_min_y};
				range_q <= {cfg.raw_max_y[31], cfg.raw_max_y} - {cfg.raw_min_y[31], cfg.raw_min_y};
			end else begin
				diff_q <= {ev_value_q[31], ev_value_q} - {cfg.raw_min_x[31], cfg.raw_min_x};
				range_q <= {cfg.raw_max_x[31], cfg.raw_max_x} - {cfg.raw_min_x[31], cfg.raw_min_x};
			end
		end
		if (state_q == ST_FIN && out_free) begin
			m_data_q <= {1'b0, (kp_q ? ev_code_q : 10'd0), kp_q, rp_q, lr_q, lp_q, redraw_q,
				12'(cursor_y_q), 12'(cursor_x_q)};
		end
	end

	// Control, cursor and button state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cursor_x_q <= '0;
			cursor_y_q <= '0;
			left_level_q <= 1'b0;
			right_level_q <= 1'b0;
			redraw_q <= 1'b0;
			lp_q <= 1'b0;
			lr_q <= 1'b0;
			rp_q <= 1'b0;
			kp_q <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			// Drop the beat once taken, unless a new one loads this cycle
			if (m_valid_q && m_axis_tready && state_q != ST_FIN) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_PREP;
					end
				end
				ST_PREP: state_q <= ST_EXEC;
				ST_EXEC: begin
					// Flags for the result beat
					redraw_q <= motion;
					kp_q <= is_key && (ev_code_q < ppt_pkg::CODE_BTN_BASE)
						&& (ev_value_q == 32'd1);
					lp_q <= is_key && (ev_code_q == ppt_pkg::CODE_BTN_LEFT)
						&& btn_down && !left_level_q;
					lr_q <= is_key && (ev_code_q == ppt_pkg::CODE_BTN_LEFT)
						&& !btn_down && left_level_q;
					rp_q <= is_key && (ev_code_q == ppt_pkg::CODE_BTN_RIGHT)
						&& btn_down && !right_level_q;
					if (is_key && ev_code_q == ppt_pkg::CODE_BTN_LEFT) begin
						left_level_q <= btn_down;
					end
					if (is_key && ev_code_q == ppt_pkg::CODE_BTN_RIGHT) begin
						right_level_q <= btn_down;
					end
					// Move the target axis and reclamp the other one
					if (motion) begin
						cursor_x_q <= (tgt_x && !need_div) ? axis_new : clamp_x;
						cursor_y_q <= (tgt_y && !need_div) ? axis_new : clamp_y;
					end
					state_q <= need_div ? ST_WAIT : ST_FIN;
				end
				ST_WAIT: begin
					if (arith_stat.done) begin
						if (tgt_y) begin
							cursor_y_q <= quo;
						end else begin
							cursor_x_q <= quo;
						end
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					// Hold until the output register is free
					if (out_free) begin
						m_valid_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`PPT_ASSERT_NOW(a_cursor_clamped, clk, arst_n, state_q == ST_FIN && redraw_q, cursor_x_q <= lim_x && cursor_y_q <= lim_y)
	`PPT_ASSERT_NOW(a_done_in_wait, clk, arst_n, arith_stat.done, state_q == ST_WAIT)
	`PPT_ASSERT_NOW(a_busy_blocks_input, clk, arst_n, arith_stat.busy, !s_axis_tready)
	`PPT_ASSERT_NEXT(a_exec_short_path, clk, arst_n, state_q == ST_EXEC && !need_div, state_q == ST_FIN)
	`PPT_ASSERT_NOW(a_key_not_motion, clk, arst_n, state_q == ST_FIN && kp_q, !redraw_q && !lp_q && !rp_q)

endmodule

/* bench/pointer_position_tracker_test.sv */
`timescale 1ns / 100ps

module pointer_position_tracker_test;

	localparam int COORD_BITS = ppt_pkg::COORD_BITS_DEF;
	localparam longint COORD_CAP = longint'(1) << COORD_BITS;
	localparam logic [2:0] REG_SPARE = 3'd7;
	localparam int PHASES = 10;
	localparam int PHASE_EVENTS = 105;
	localparam int HOLD_CYCLES = 300;
	localparam int SETTLE_CYCLES = 8;
	localparam int DRAIN_CYCLES = 40;
	localparam longint TIMEOUT_NS = 4_000_000;
	localparam logic signed [31:0] RAW_LOWEST = 32'sh8000_0000;
	localparam logic signed [31:0] RAW_HIGHEST = 32'sh7fff_ffff;

	// One input event, kept as raw bits
	typedef struct packed {
		logic [4:0] kind;
		logic [9:0] code;
		logic [31:0] value;
		logic dev;
	} pointer_event_t;

	// Result beat, laid out as on m_axis_tdata[38:0]
	typedef struct packed {
		logic [9:0] key_code;
		logic key_pressed;
		logic right_pressed;
		logic left_released;
		logic left_pressed;
		logic redraw;
		logic [11:0] cursor_y;
		logic [11:0] cursor_x;
	} cursor_report_t;

	logic clk;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [ppt_pkg::S_TDATA_W-1:0] s_axis_tdata = '0;
	logic [ppt_pkg::S_TUSER_W-1:0] s_axis_tuser = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [ppt_pkg::M_TDATA_W-1:0] m_axis_tdata;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [ppt_pkg::APB_ADDR_W-1:0] paddr = '0;
	logic [ppt_pkg::APB_DATA_W-1:0] pwdata = '0;
	logic [ppt_pkg::APB_DATA_W-1:0] prdata;
	logic pready;

	// Register shadows
	logic [12:0] width_cfg = ppt_pkg::RST_SCREEN_WIDTH;
	logic [12:0] height_cfg = ppt_pkg::RST_SCREEN_HEIGHT;
	logic signed [31:0] min_x_cfg = ppt_pkg::RST_RAW_MIN;
	logic signed [31:0] max_x_cfg = ppt_pkg::RST_RAW_MAX;
	logic signed [31:0] min_y_cfg = ppt_pkg::RST_RAW_MIN;
	logic signed [31:0] max_y_cfg = ppt_pkg::RST_RAW_MAX;
	logic [1:0] mask_cfg = ppt_pkg::RST_ABS_MASK;

	// Tracked cursor and button levels
	longint pos_x = 0;
	longint pos_y = 0;
	logic left_down = 1'b0;
	logic right_down = 1'b0;

	pointer_event_t pending_events[$];
	cursor_report_t expected_reports[$];
	int mismatch_count = 0;
	int result_index = 0;

	// Idle behavior: 0 none, 1 always random, 2 occasional
	int tx_mode = 0;
	int rx_mode = 0;
	int hold_asked = 0;
	int hold_served = 0;
	int tx_wait = 0;
	int rx_wait = 0;
	logic offering = 1'b0;
	pointer_event_t cur_event;

	pointer_position_tracker dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Largest coordinate an axis may hold for a given screen register
	function automatic longint axis_limit(logic [12:0] screen);
		if (screen == 0)
			return 0;
		if (longint'(screen) > COORD_CAP)
			return COORD_CAP - 1;
		return longint'(screen) - 1;
	endfunction

	function automatic longint clamp_to(longint v, longint lim);
		if (v < 0)
			return 0;
		if (v > lim)
			return lim;
		return v;
	endfunction

	// Scale a raw absolute reading by lim over the range, floor of the exact quotient
	function automatic longint scale_position(longint raw, longint lo, longint hi,
			longint lim, longint keep);
		longint num;
		if (hi <= lo)
			return keep;
		num = (raw - lo) * lim;
		if (num < 0)
			return 0;
		return num / (hi - lo);
	endfunction

	// Advance the tracked state by one event and return the result it gives
	function automatic cursor_report_t track_event(pointer_event_t ev);
		cursor_report_t r;
		longint v;
		longint lim_x;
		longint lim_y;
		logic down;
		v = longint'($signed(ev.value));
		lim_x = axis_limit(width_cfg);
		lim_y = axis_limit(height_cfg);
		r = '0;
		if (ev.kind == ppt_pkg::EVT_KEY && ev.code < ppt_pkg::CODE_BTN_BASE && v == 1) begin
			r.key_pressed = 1'b1;
			r.key_code = ev.code;
		end
		if (ev.kind == ppt_pkg::EVT_REL) begin
			if (ev.code == ppt_pkg::AXIS_X)
				pos_x = pos_x + v;
			else if (ev.code == ppt_pkg::AXIS_Y)
				pos_y = pos_y + v;
			pos_x = clamp_to(pos_x, lim_x);
			pos_y = clamp_to(pos_y, lim_y);
			r.redraw = 1'b1;
		end
		if (ev.kind == ppt_pkg::EVT_ABS && mask_cfg[ev.dev]) begin
			if (ev.code == ppt_pkg::AXIS_X)
				pos_x = scale_position(v, longint'(min_x_cfg), longint'(max_x_cfg),
					lim_x, pos_x);
			else if (ev.code == ppt_pkg::AXIS_Y)
				pos_y = scale_position(v, longint'(min_y_cfg), longint'(max_y_cfg),
					lim_y, pos_y);
			pos_x = clamp_to(pos_x, lim_x);
			pos_y = clamp_to(pos_y, lim_y);
			r.redraw = 1'b1;
		end
		if (ev.kind == ppt_pkg::EVT_KEY) begin
			down = (v != 0);
			if (ev.code == ppt_pkg::CODE_BTN_RIGHT) begin
				r.right_pressed = down && !right_down;
				right_down = down;
			end
			if (ev.code == ppt_pkg::CODE_BTN_LEFT) begin
				r.left_pressed = down && !left_down;
				r.left_released = !down && left_down;
				left_down = down;
			end
		end
		r.cursor_x = pos_x[11:0];
		r.cursor_y = pos_y[11:0];
		return r;
	endfunction

	function automatic int draw_wait(int mode);
		if (mode == 1)
			return $urandom_range(0, 14);
		if (mode == 2 && $urandom_range(0, 3) == 0)
			return $urandom_range(0, 14);
		return 0;
	endfunction

	task automatic flag_mismatch(string what, longint want, longint got);
		mismatch_count++;
		$display("mismatch at result %0d: %s expected %0d got %0d",
			result_index, what, want, got);
	endtask

	task automatic check_report(logic [ppt_pkg::M_TDATA_W-1:0] beat);
		cursor_report_t got;
		cursor_report_t want;
		got = beat[38:0];
		if (expected_reports.size() == 0) begin
			flag_mismatch("result beat with none pending, raw bits", 0, beat);
			return;
		end
		want = expected_reports.pop_front();
		if (got.cursor_x !== want.cursor_x)
			flag_mismatch("cursor_x", want.cursor_x, got.cursor_x);
		if (got.cursor_y !== want.cursor_y)
			flag_mismatch("cursor_y", want.cursor_y, got.cursor_y);
		if (got.redraw !== want.redraw)
			flag_mismatch("redraw", want.redraw, got.redraw);
		if (got.left_pressed !== want.left_pressed)
			flag_mismatch("left_pressed", want.left_pressed, got.left_pressed);
		if (got.left_released !== want.left_released)
			flag_mismatch("left_released", want.left_released, got.left_released);
		if (got.right_pressed !== want.right_pressed)
			flag_mismatch("right_pressed", want.right_pressed, got.right_pressed);
		if (got.key_pressed !== want.key_pressed)
			flag_mismatch("key_pressed", want.key_pressed, got.key_pressed);
		if (got.key_code !== want.key_code)
			flag_mismatch("key_code", want.key_code, got.key_code);
		if (beat[39] !== 1'b0)
			flag_mismatch("pad bit", 0, beat[39]);
	endtask

	// Sender: offer queued events, wait the drawn gap after each beat
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			offering = 1'b0;
			tx_wait = 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				expected_reports.push_back(track_event(cur_event));
				offering = 1'b0;
				tx_wait = draw_wait(tx_mode);
			end else if (!offering && tx_wait > 0) begin
				tx_wait--;
			end
			if (!offering && tx_wait == 0 && pending_events.size() > 0) begin
				cur_event = pending_events.pop_front();
				offering = 1'b1;
				s_axis_tdata <= {5'b0, cur_event.dev, cur_event.value, cur_event.code};
				s_axis_tuser <= cur_event.kind;
			end
			s_axis_tvalid <= offering;
		end
	end

	// Receiver: check each result beat, then stall for the drawn count
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			rx_wait = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				check_report(m_axis_tdata);
				result_index++;
				rx_wait = draw_wait(rx_mode);
			end else if (!m_axis_tready && rx_wait > 0) begin
				rx_wait--;
			end
			if (hold_served != hold_asked) begin
				hold_served = hold_asked;
				rx_wait = HOLD_CYCLES;
			end
			m_axis_tready <= (rx_wait == 0);
		end
	end

	// Register write: setup phase, then access phase
	task automatic reg_write(logic [2:0] idx, logic [31:0] data);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			ppt_pkg::REG_SCREEN_WIDTH: width_cfg = data[12:0];
			ppt_pkg::REG_SCREEN_HEIGHT: height_cfg = data[12:0];
			ppt_pkg::REG_RAW_MIN_X: min_x_cfg = data;
			ppt_pkg::REG_RAW_MAX_X: max_x_cfg = data;
			ppt_pkg::REG_RAW_MIN_Y: min_y_cfg = data;
			ppt_pkg::REG_RAW_MAX_Y: max_y_cfg = data;
			ppt_pkg::REG_ABS_MASK: mask_cfg = data[1:0];
			default: ;
		endcase
	endtask

	task automatic write_all(logic [12:0] w, logic [12:0] h,
			logic signed [31:0] lo_x, logic signed [31:0] hi_x,
			logic signed [31:0] lo_y, logic signed [31:0] hi_y, logic [1:0] mask);
		reg_write(ppt_pkg::REG_SCREEN_WIDTH, w);
		reg_write(ppt_pkg::REG_SCREEN_HEIGHT, h);
		reg_write(ppt_pkg::REG_RAW_MIN_X, lo_x);
		reg_write(ppt_pkg::REG_RAW_MAX_X, hi_x);
		reg_write(ppt_pkg::REG_RAW_MIN_Y, lo_y);
		reg_write(ppt_pkg::REG_RAW_MAX_Y, hi_y);
		reg_write(ppt_pkg::REG_ABS_MASK, mask);
		@(negedge clk);
	endtask

	// Wait until every queued event is through and every result checked
	task automatic settle();
		do
			@(negedge clk);
		while (pending_events.size() != 0 || s_axis_tvalid || expected_reports.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic send(logic [4:0] kind, logic [9:0] code, logic [31:0] value, logic dev);
		pending_events.push_back('{kind: kind, code: code, value: value, dev: dev});
	endtask

	function automatic logic [12:0] pick_screen();
		if ($urandom_range(0, 3) == 0)
			return $urandom_range(0, 8191);
		return $urandom_range(1, 4096);
	endfunction

	task automatic pick_range(output logic signed [31:0] lo, output logic signed [31:0] hi);
		logic signed [31:0] t;
		int sel;
		sel = $urandom_range(0, 9);
		if (sel < 6) begin
			lo = int'($urandom_range(0, 4000)) - 2000;
			hi = lo + int'($urandom_range(1, 70000));
		end else begin
			lo = $urandom;
			hi = $urandom;
			// mostly ordered; leave the last case in any order
			if (sel < 9 && hi < lo) begin
				t = lo;
				lo = hi;
				hi = t;
			end
		end
	endtask

	function automatic logic [9:0] random_axis();
		int sel;
		sel = $urandom_range(0, 19);
		if (sel < 9)
			return ppt_pkg::AXIS_X;
		if (sel < 18)
			return ppt_pkg::AXIS_Y;
		return $urandom_range(0, 1023);
	endfunction

	function automatic logic [31:0] key_state();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel < 4)
			return 0;
		if (sel < 7)
			return 1;
		if (sel < 9)
			return 2;
		return $urandom;
	endfunction

	// Raw reading: the range ends, inside the range, or anything at all
	function automatic logic [31:0] raw_sample(logic signed [31:0] lo, logic signed [31:0] hi);
		longint span;
		span = longint'(hi) - longint'(lo);
		case ($urandom_range(0, 9))
			0: return lo;
			1: return hi;
			2: return $urandom;
			default: begin
				if (span <= 0)
					return $urandom;
				return 32'(longint'(lo) + longint'($urandom) % (span + 1));
			end
		endcase
	endfunction

	function automatic pointer_event_t random_event();
		pointer_event_t ev;
		int sel;
		ev.dev = $urandom_range(0, 1);
		sel = $urandom_range(0, 99);
		if (sel < 30) begin
			ev.kind = ppt_pkg::EVT_REL;
			ev.code = random_axis();
			if ($urandom_range(0, 9) < 8)
				ev.value = int'($urandom_range(0, 160)) - 80;
			else
				ev.value = $urandom;
		end else if (sel < 55) begin
			ev.kind = ppt_pkg::EVT_ABS;
			ev.code = random_axis();
			if (ev.code == ppt_pkg::AXIS_Y)
				ev.value = raw_sample(min_y_cfg, max_y_cfg);
			else
				ev.value = raw_sample(min_x_cfg, max_x_cfg);
		end else if (sel < 78) begin
			ev.kind = ppt_pkg::EVT_KEY;
			ev.code = $urandom_range(0, 1) ? ppt_pkg::CODE_BTN_LEFT : ppt_pkg::CODE_BTN_RIGHT;
			ev.value = key_state();
		end else if (sel < 90) begin
			ev.kind = ppt_pkg::EVT_KEY;
			ev.code = $urandom_range(0, ppt_pkg::CODE_BTN_BASE - 1);
			ev.value = key_state();
		end else begin
			ev.kind = $urandom_range(0, 31);
			ev.code = $urandom_range(0, 1023);
			ev.value = $urandom;
		end
		return ev;
	endfunction

	initial begin
		logic signed [31:0] lo_x;
		logic signed [31:0] hi_x;
		logic signed [31:0] lo_y;
		logic signed [31:0] hi_y;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset defaults: motion extremes, ignored absolute, buttons, keys, noise
		send(ppt_pkg::EVT_REL, ppt_pkg::AXIS_X, 100, 1'b0);
		send(ppt_pkg::EVT_REL, ppt_pkg::AXIS_Y, 50, 1'b1);
		send(ppt_pkg::EVT_REL, ppt_pkg::AXIS_X, RAW_HIGHEST, 1'b0);
		send(ppt_pkg::EVT_REL, ppt_pkg::AXIS_Y, RAW_LOWEST, 1'b0);
		send(ppt_pkg::EVT_REL, 10'd5, 7, 1'b1);
		send(ppt_pkg::EVT_ABS, ppt_pkg::AXIS_X, 1000, 1'b0);
		send(ppt_pkg::EVT_KEY, ppt_pkg::CODE_BTN_LEFT, 1, 1'b0);
		send(ppt_pkg::EVT_KEY, ppt_pkg::CODE_BTN_LEFT, 2, 1'b0);
		send(ppt_pkg::EVT_KEY, ppt_pkg::CODE_BTN_LEFT, 0, 1'b0);
		send(ppt_pkg::EVT_KEY, ppt_pkg::CODE_BTN_RIGHT, 2, 1'b1);
		send(ppt_pkg::EVT_KEY, ppt_pkg::CODE_BTN_RIGHT, 0, 1'b1);
		send(ppt_pkg::EVT_KEY, ppt_pkg::CODE_BTN_BASE - 10'd1, 1, 1'b0);
		send(ppt_pkg::EVT_KEY, 10'd0, 2, 1'b0);
		send(ppt_pkg::EVT_KEY, 10'h3ff, 1, 1'b1);
		send(5'd31, ppt_pkg::AXIS_X, 5, 1'b0);
		settle();

		// Only device 1 absolute; empty y range keeps y
		write_all(ppt_pkg::RST_SCREEN_WIDTH, ppt_pkg::RST_SCREEN_HEIGHT, -100, 100, 5, 5,
			2'b10);
		send(ppt_pkg::EVT_ABS, ppt_pkg::AXIS_X, 50, 1'b0);
		send(ppt_pkg::EVT_ABS, ppt_pkg::AXIS_X, 0, 1'b1);
		send(ppt_pkg::EVT_ABS, ppt_pkg::AXIS_X, RAW_LOWEST, 1'b1);
		send(ppt_pkg::EVT_ABS, ppt_pkg::AXIS_X, RAW_HIGHEST, 1'b1);
		send(ppt_pkg::EVT_ABS, 10'd7, 3, 1'b1);
		send(ppt_pkg::EVT_ABS, ppt_pkg::AXIS_Y, 5, 1'b1);
		settle();

		// Oversized screen, then shrink without motion, then a zero screen
		reg_write(ppt_pkg::REG_SCREEN_WIDTH, 13'd4096);
		reg_write(ppt_pkg::REG_SCREEN_HEIGHT, 13'd8191);
		@(negedge clk);
		send(ppt_pkg::EVT_REL, ppt_pkg::AXIS_X, 3000, 1'b0);
		send(ppt_pkg::EVT_REL, ppt_pkg::AXIS_Y, 100000, 1'b0);
		settle();
		reg_write(ppt_pkg::REG_SCREEN_WIDTH, 13'd10);
		reg_write(REG_SPARE, 32'hffff_ffff);
		@(negedge clk);
		send(ppt_pkg::EVT_KEY, 10'd30, 1, 1'b0);
		send(ppt_pkg::EVT_REL, ppt_pkg::AXIS_Y, 0, 1'b0);
		settle();
		reg_write(ppt_pkg::REG_SCREEN_WIDTH, 13'd0);
		@(negedge clk);
		send(ppt_pkg::EVT_REL, ppt_pkg::AXIS_X, 5, 1'b1);
		settle();

		// Random phases, each under its own register setting and idle pattern
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: write_all(ppt_pkg::RST_SCREEN_WIDTH, ppt_pkg::RST_SCREEN_HEIGHT,
					ppt_pkg::RST_RAW_MIN, ppt_pkg::RST_RAW_MAX,
					ppt_pkg::RST_RAW_MIN, ppt_pkg::RST_RAW_MAX, 2'b11);
				1: write_all(13'd1, 13'd1, RAW_LOWEST, RAW_HIGHEST, RAW_LOWEST, RAW_HIGHEST,
					2'b01);
				2: write_all(13'd4096, 13'd4096, -1000, 1000, 50, 60, 2'b10);
				3: write_all(13'd0, 13'd8191, 10, 10, 100, 50, 2'b11);
				default: begin
					pick_range(lo_x, hi_x);
					pick_range(lo_y, hi_y);
					write_all(pick_screen(), pick_screen(), lo_x, hi_x, lo_y, hi_y,
						2'($urandom_range(0, 3)));
				end
			endcase
			tx_mode = p % 3;
			rx_mode = (p / 3) % 3;
			// hold the result side off while the sender keeps offering
			if (p == 2)
				hold_asked++;
			for (int i = 0; i < PHASE_EVENTS; i++) begin
				// pause the sender mid-phase until every result is back
				if (p == 5 && i == PHASE_EVENTS / 2)
					settle();
				pending_events.push_back(random_event());
			end
			settle();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("pointer_position_tracker_test: PASS");
		else
			$display("pointer_position_tracker_test: FAIL");
		$finish;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("pointer_position_tracker_test: FAIL");
		$finish;
	end

endmodule
